[rtl/vibration_motor_pulse_sequencer_unit_defines.svh]
// assertion macros for the sequencer rtl, used by the controller
`ifndef VIBRATION_MOTOR_PULSE_SEQUENCER_UNIT_DEFINES_SVH
`define VIBRATION_MOTOR_PULSE_SEQUENCER_UNIT_DEFINES_SVH

// checked only while out of reset
`define VMPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define VMPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[rtl/vmps_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vmps_pkg;

  localparam int unsigned PAD_COUNT_DEF = 4;

  // request codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_e;

  // motor actions reported per pad
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } act_e;

  // per-pad modes
  typedef enum logic [2:0] {
    MODE_ENABLING     = 3'd0,
    MODE_EN_STOPPED   = 3'd1,
    MODE_EN_STARTING  = 3'd2,
    MODE_EN_RUMBLING  = 3'd3,
    MODE_EN_STOPPING  = 3'd4,
    MODE_DIS_STOPPING = 3'd5,
    MODE_DIS_STOPPED  = 3'd6
  } mode_e;

  localparam logic signed [16:0] ON_NONE    = -17'sd1;
  localparam logic signed [17:0] LIFE_NONE  = -18'sd1;
  localparam logic signed [17:0] LIFE_FLOOR = -18'sd2;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic step;
    logic last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic op_tick;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/vmps_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "vibration_motor_pulse_sequencer_unit_defines.svh"

module vmps_ctrl #(
  parameter int unsigned PAD_COUNT = vmps_pkg::PAD_COUNT_DEF,
  localparam int unsigned IdxW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  vmps_pkg::dp_sts_t sts_i,
  output vmps_pkg::dp_cmd_t cmd_o,
  output logic [IdxW-1:0]   idx_o
);
  import vmps_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_REQ  = 3'b100
  } ctrl_state_e;

  ctrl_state_e     state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            last_idx;

  assign last_idx   = (idx_q == IdxW'(PAD_COUNT - 1));
  assign in_stall_o = (state_q != ST_IDLE);
  assign idx_o      = idx_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          idx_d         = '0;
          state_d       = sts_i.op_tick ? ST_WALK : ST_REQ;
        end
      end
      ST_WALK: begin
        cmd_o.step = sts_i.out_free;
        cmd_o.last = last_idx;
        if (sts_i.out_free) begin
          if (last_idx) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_REQ: begin
        cmd_o.step = sts_i.out_free;
        cmd_o.last = 1'b1;
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  `VMPS_ASSERT(a_step_not_idle, cmd_o.step |-> (state_q != ST_IDLE), "step issued while idle")
  `VMPS_ASSERT(a_idx_range, (32'(idx_q) < PAD_COUNT), "pad pointer out of range")
  `VMPS_ASSERT(a_accept_busy, cmd_o.capture |=> (state_q != ST_IDLE), "accept did not start work")

endmodule

`default_nettype wire

[rtl/vmps_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module vmps_dp #(
  parameter int unsigned PAD_COUNT = vmps_pkg::PAD_COUNT_DEF,
  localparam int unsigned IdxW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_enable_i,
  input  logic [1:0]         op_i,
  input  logic [1:0]         pad_i,
  input  logic [15:0]        duration_ticks_i,
  input  logic signed [16:0] on_ticks_i,
  input  logic [15:0]        off_ticks_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [1:0]         pad_res_o,
  output logic [1:0]         motor_action_o,
  output logic               accepted_o,
  output logic               last_o,
  input  vmps_pkg::dp_cmd_t  cmd_i,
  input  logic [IdxW-1:0]    idx_i,
  output vmps_pkg::dp_sts_t  sts_o
);
  import vmps_pkg::*;

  logic enable_q;

  // captured request
  logic [1:0]         op_q;
  logic [1:0]         pad_q;
  logic [15:0]        dur_q;
  logic signed [16:0] on_q;
  logic [15:0]        off_q;

  // per-pad state
  mode_e              mode_q   [PAD_COUNT];
  logic signed [17:0] life_q   [PAD_COUNT];
  logic signed [16:0] pon_q    [PAD_COUNT];
  logic signed [17:0] period_q [PAD_COUNT];
  logic [17:0]        count_q  [PAD_COUNT];

  // result register
  logic       out_valid_q;
  logic [1:0] pad_res_q;
  logic [1:0] act_q;
  logic       acc_q;
  logic       last_q;

  logic               is_tick, pad_ok, out_free, wr_en;
  logic [IdxW-1:0]    req_idx, sel_idx;
  mode_e              rd_mode, nx_mode;
  logic signed [17:0] rd_life, nx_life, life_dec;
  logic signed [16:0] rd_pon, nx_pon;
  logic signed [17:0] rd_per, nx_per;
  logic [17:0]        rd_cnt, nx_cnt, cnt_inc;
  act_e               act;
  logic               acc;
  logic [1:0]         res_pad;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign sts_o.out_free = out_free;
  assign sts_o.op_tick  = (op_i == OP_TICK);

  assign is_tick = (op_q == OP_TICK);
  assign pad_ok  = (32'(pad_q) < PAD_COUNT);
  assign req_idx = IdxW'(pad_q);
  assign sel_idx = is_tick ? idx_i : req_idx;

  assign rd_mode = mode_q[sel_idx];
  assign rd_life = life_q[sel_idx];
  assign rd_pon  = pon_q[sel_idx];
  assign rd_per  = period_q[sel_idx];
  assign rd_cnt  = count_q[sel_idx];

  assign cnt_inc  = rd_cnt + 18'd1;
  assign life_dec = (rd_life > LIFE_FLOOR) ? (rd_life - 18'sd1) : rd_life;

  always_comb begin
    nx_mode = rd_mode;
    nx_life = rd_life;
    nx_pon  = rd_pon;
    nx_per  = rd_per;
    nx_cnt  = rd_cnt;
    act     = ACT_NONE;
    acc     = 1'b0;
    case (op_q)
      OP_TICK: begin
        if (enable_q) begin
          case (rd_mode)
            MODE_EN_STARTING: begin
              nx_mode = MODE_EN_RUMBLING;
              act     = ACT_START;
            end
            MODE_EN_RUMBLING: begin
              if (rd_pon != ON_NONE) begin
                if (rd_cnt == 18'd0) begin
                  act = ACT_START;
                end else if (!rd_pon[16] && ({1'b0, rd_pon} == rd_cnt)) begin
                  act = ACT_STOP;
                end
                // period wrap only for a non-negative period
                if (!rd_per[17] && ($unsigned(rd_per) == cnt_inc)) begin
                  nx_cnt = '0;
                end else begin
                  nx_cnt = cnt_inc;
                end
              end
              nx_life = life_dec;
              if (life_dec[17]) begin
                nx_mode = MODE_EN_STOPPING;
              end
            end
            MODE_EN_STOPPING: begin
              nx_mode = MODE_EN_STOPPED;
              act     = ACT_STOP;
            end
            MODE_DIS_STOPPING: begin
              nx_mode = MODE_DIS_STOPPED;
              act     = ACT_STOP;
            end
            MODE_ENABLING: begin
              nx_mode = MODE_EN_STOPPED;
              nx_life = LIFE_NONE;
            end
            default: ;
          endcase
        end
      end
      OP_START: begin
        if (pad_ok && enable_q && (rd_mode != MODE_DIS_STOPPING)
            && (rd_mode != MODE_DIS_STOPPED) && (rd_life < $signed({2'b00, dur_q}))) begin
          nx_mode = MODE_EN_STARTING;
          nx_life = $signed({2'b00, dur_q});
          nx_pon  = on_q;
          nx_per  = $signed({on_q[16], on_q}) + $signed({2'b00, off_q});
          nx_cnt  = '0;
          acc     = 1'b1;
        end
      end
      OP_STOP: begin
        if (pad_ok) begin
          if ((rd_mode != MODE_DIS_STOPPING) && (rd_mode != MODE_DIS_STOPPED)) begin
            nx_mode = MODE_EN_STOPPING;
          end
          nx_life = LIFE_NONE;
          acc     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign wr_en   = cmd_i.step && (is_tick || pad_ok);
  assign res_pad = is_tick ? 2'(idx_i) : pad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_valid_i) begin
      enable_q <= cfg_enable_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      pad_q <= pad_i;
      dur_q <= duration_ticks_i;
      on_q  <= on_ticks_i;
      off_q <= off_ticks_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAD_COUNT; i++) begin
        mode_q[i]   <= MODE_ENABLING;
        life_q[i]   <= LIFE_NONE;
        pon_q[i]    <= ON_NONE;
        period_q[i] <= '0;
        count_q[i]  <= '0;
      end
    end else if (wr_en) begin
      mode_q[sel_idx]   <= nx_mode;
      life_q[sel_idx]   <= nx_life;
      pon_q[sel_idx]    <= nx_pon;
      period_q[sel_idx] <= nx_per;
      count_q[sel_idx]  <= nx_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      pad_res_q <= res_pad;
      act_q     <= act;
      acc_q     <= acc;
      last_q    <= cmd_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pad_res_o      = pad_res_q;
  assign motor_action_o = act_q;
  assign accepted_o     = acc_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

[rtl/vibration_motor_pulse_sequencer_unit.sv]
// a request is captured, then each step writes the result register; no new request
// is taken until the last step is done. A tick walks one pad a cycle through the shared
// update unit while the output is not stalled; a start or stop takes a single step
// reset: every pad enabling, life and on-time -1, period and counter 0, enable 0
`timescale 1ns / 1ps
`default_nettype none

module vibration_motor_pulse_sequencer_unit #(
  parameter int unsigned PAD_COUNT = vmps_pkg::PAD_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration channel, enable register only
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_enable_i,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         op_i,
  input  logic [1:0]         pad_i,
  input  logic [15:0]        duration_ticks_i,
  input  logic signed [16:0] on_ticks_i,
  input  logic [15:0]        off_ticks_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         pad_res_o,
  output logic [1:0]         motor_action_o,
  output logic               accepted_o,
  output logic               last_o
);
  import vmps_pkg::*;

  localparam int unsigned IdxW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

  dp_cmd_t         cmd;
  dp_sts_t         sts;
  logic [IdxW-1:0] idx;

  // sequencer: idle, pad walk for a tick, single step for a start, a stop or the spare op
  vmps_ctrl #(
    .PAD_COUNT(PAD_COUNT)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .idx_o     (idx)
  );

  // pad state, shared update unit and result register
  vmps_dp #(
    .PAD_COUNT(PAD_COUNT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_enable_i    (cfg_enable_i),
    .op_i            (op_i),
    .pad_i           (pad_i),
    .duration_ticks_i(duration_ticks_i),
    .on_ticks_i      (on_ticks_i),
    .off_ticks_i     (off_ticks_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .pad_res_o       (pad_res_o),
    .motor_action_o  (motor_action_o),
    .accepted_o      (accepted_o),
    .last_o          (last_o),
    .cmd_i           (cmd),
    .idx_i           (idx),
    .sts_o           (sts)
  );

endmodule

`default_nettype wire

[verif/vibration_motor_pulse_sequencer_checker.sv]
`timescale 1ns / 1ps

module vibration_motor_pulse_sequencer_checker #(
  parameter int unsigned PAD_COUNT = vmps_pkg::PAD_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_enable_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         op_i,
  input  logic [1:0]         pad_i,
  input  logic [15:0]        duration_ticks_i,
  input  logic signed [16:0] on_ticks_i,
  input  logic [15:0]        off_ticks_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [1:0]         pad_res_i,
  input  logic [1:0]         motor_action_i,
  input  logic               accepted_i,
  input  logic               last_i,
  output int                 mismatch_count_o,
  output int                 results_due_o
);
  import vmps_pkg::*;

  localparam logic signed [17:0] LIFE_IDLE     = -18'sd1;
  localparam logic signed [17:0] LIFE_FLOOR    = -18'sd2;
  localparam logic signed [16:0] ON_CONTINUOUS = -17'sd1;

  typedef struct packed {
    logic [1:0] pad;
    act_e       action;
    logic       accepted;
    logic       last;
  } pad_report_t;

  pad_report_t        reports_due[$];
  logic               enable_q;
  mode_e              mode_q   [PAD_COUNT];
  logic signed [17:0] life_q   [PAD_COUNT];
  logic signed [16:0] on_q     [PAD_COUNT];
  logic signed [17:0] period_q [PAD_COUNT];
  logic [17:0]        count_q  [PAD_COUNT];

  // advance the pad model by one request and queue the reports it causes
  task automatic predict_request(input logic [1:0] op, input logic [1:0] pad,
                                 input logic [15:0] dur, input logic signed [16:0] on,
                                 input logic [15:0] off);
    pad_report_t rep;
    act_e        act;
    logic        taken;
    begin
      rep.pad      = pad;
      rep.action   = ACT_NONE;
      rep.accepted = 1'b0;
      rep.last     = 1'b1;
      case (op_e'(op))
        OP_TICK: begin
          for (int p = 0; p < PAD_COUNT; p++) begin
            act = ACT_NONE;
            if (enable_q) begin
              case (mode_q[p])
                MODE_EN_STARTING: begin
                  mode_q[p] = MODE_EN_RUMBLING;
                  act       = ACT_START;
                end
                MODE_EN_RUMBLING: begin
                  if (on_q[p] != ON_CONTINUOUS) begin
                    if (count_q[p] == '0)
                      act = ACT_START;
                    else if (!on_q[p][16] && count_q[p] == {1'b0, on_q[p]})
                      act = ACT_STOP;
                    count_q[p] = count_q[p] + 18'd1;
                    // a negative period never matches the counter
                    if (!period_q[p][17] && count_q[p] == $unsigned(period_q[p]))
                      count_q[p] = '0;
                  end
                  if (life_q[p] > LIFE_FLOOR)
                    life_q[p] = life_q[p] - 18'sd1;
                  if (life_q[p] < 0)
                    mode_q[p] = MODE_EN_STOPPING;
                end
                MODE_EN_STOPPING: begin
                  mode_q[p] = MODE_EN_STOPPED;
                  act       = ACT_STOP;
                end
                MODE_DIS_STOPPING: begin
                  mode_q[p] = MODE_DIS_STOPPED;
                  act       = ACT_STOP;
                end
                MODE_ENABLING: begin
                  mode_q[p] = MODE_EN_STOPPED;
                  life_q[p] = LIFE_IDLE;
                end
                default: ;
              endcase
            end
            rep.pad    = 2'(p);
            rep.action = act;
            rep.last   = (p == PAD_COUNT - 1);
            reports_due.push_back(rep);
          end
        end
        OP_START: begin
          taken = 1'b0;
          if (pad < PAD_COUNT) begin
            taken = enable_q && mode_q[pad] != MODE_DIS_STOPPING
                    && mode_q[pad] != MODE_DIS_STOPPED
                    && life_q[pad] < $signed({2'b00, dur});
            if (taken) begin
              mode_q[pad]   = MODE_EN_STARTING;
              life_q[pad]   = $signed({2'b00, dur});
              on_q[pad]     = on;
              period_q[pad] = $signed({on[16], on}) + $signed({2'b00, off});
              count_q[pad]  = '0;
            end
          end
          rep.accepted = taken;
          reports_due.push_back(rep);
        end
        OP_STOP: begin
          if (pad < PAD_COUNT) begin
            if (mode_q[pad] != MODE_DIS_STOPPING && mode_q[pad] != MODE_DIS_STOPPED)
              mode_q[pad] = MODE_EN_STOPPING;
            life_q[pad]  = LIFE_IDLE;
            rep.accepted = 1'b1;
          end
          reports_due.push_back(rep);
        end
        // spare op code answers with a bare report
        default: reports_due.push_back(rep);
      endcase
    end
  endtask

  task automatic compare_report();
    pad_report_t want;
    begin
      if (reports_due.size() == 0) begin
        $error("result transaction with nothing outstanding: pad_res %0d motor_action %0d",
               pad_res_i, motor_action_i);
        mismatch_count_o++;
      end else begin
        want = reports_due.pop_front();
        if (pad_res_i !== want.pad) begin
          $error("pad_res: expected %0d, got %0d", want.pad, pad_res_i);
          mismatch_count_o++;
        end
        if (motor_action_i !== want.action) begin
          $error("motor_action: expected %0d, got %0d", want.action, motor_action_i);
          mismatch_count_o++;
        end
        if (accepted_i !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, accepted_i);
          mismatch_count_o++;
        end
        if (last_i !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_i);
          mismatch_count_o++;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q = 1'b0;
      for (int p = 0; p < PAD_COUNT; p++) begin
        mode_q[p]   = MODE_ENABLING;
        life_q[p]   = LIFE_IDLE;
        on_q[p]     = ON_CONTINUOUS;
        period_q[p] = '0;
        count_q[p]  = '0;
      end
      reports_due.delete();
      mismatch_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i)
        enable_q = cfg_enable_i;
      if (in_valid_i && !in_stall_i)
        predict_request(op_i, pad_i, duration_ticks_i, on_ticks_i, off_ticks_i);
      if (out_valid_i && !out_stall_i)
        compare_report();
    end
    results_due_o = reports_due.size();
  end

endmodule

[verif/vibration_motor_pulse_sequencer_unit_tb.sv]
`timescale 1ns / 1ps

module vibration_motor_pulse_sequencer_unit_tb;
  import vmps_pkg::*;

  localparam int unsigned PAD_COUNT   = vmps_pkg::PAD_COUNT_DEF;
  // generous bound on the run length for a few hundred requests
  localparam int          CYCLE_LIMIT = 200000;
  // the op code the block leaves unused
  localparam logic [1:0]  OP_SPARE    = 2'd3;
  localparam logic signed [16:0] ON_CONTINUOUS = -17'sd1;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_enable_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         op_i;
  logic [1:0]         pad_i;
  logic [15:0]        duration_ticks_i;
  logic signed [16:0] on_ticks_i;
  logic [15:0]        off_ticks_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         pad_res_o;
  logic [1:0]         motor_action_o;
  logic               accepted_o;
  logic               last_o;

  int mismatch_count;
  int results_due;
  int cycle_count = 0;
  int stall_left  = 0;
  // a result transaction took place at the last rising edge
  bit out_taken   = 1'b0;
  // when set, neither side inserts idle cycles
  bit calm        = 1'b0;

  vibration_motor_pulse_sequencer_unit #(.PAD_COUNT(PAD_COUNT)) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_enable_i     (cfg_enable_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .pad_i            (pad_i),
    .duration_ticks_i (duration_ticks_i),
    .on_ticks_i       (on_ticks_i),
    .off_ticks_i      (off_ticks_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pad_res_o        (pad_res_o),
    .motor_action_o   (motor_action_o),
    .accepted_o       (accepted_o),
    .last_o           (last_o)
  );

  vibration_motor_pulse_sequencer_checker #(.PAD_COUNT(PAD_COUNT)) checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_enable_i     (cfg_enable_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .op_i             (op_i),
    .pad_i            (pad_i),
    .duration_ticks_i (duration_ticks_i),
    .on_ticks_i       (on_ticks_i),
    .off_ticks_i      (off_ticks_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pad_res_i        (pad_res_o),
    .motor_action_i   (motor_action_o),
    .accepted_i       (accepted_o),
    .last_i           (last_o),
    .mismatch_count_o (mismatch_count),
    .results_due_o    (results_due)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  // result side back-pressure: after every result transaction a fresh stall length is drawn
  always @(posedge clk_i) begin
    out_taken = rst_ni && out_valid_o && !out_stall_i;
  end

  always @(negedge clk_i) begin
    if (out_taken)
      stall_left = draw_gap();
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // one request transaction; entered and left at a falling edge, valid left high
  // so that a back-to-back request never lowers and raises it in one step
  task automatic send_request(input logic [1:0] op, input logic [1:0] pad,
                              input logic [15:0] dur, input logic signed [16:0] on,
                              input logic [15:0] off);
    int gap;
    begin
      gap = draw_gap();
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      op_i             = op;
      pad_i            = pad;
      duration_ticks_i = dur;
      on_ticks_i       = on;
      off_ticks_i      = off;
      in_valid_i       = 1'b1;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  endtask

  // hold the request side off until every outstanding result has arrived
  task automatic drain();
    begin
      in_valid_i = 1'b0;
      while (results_due != 0) @(negedge clk_i);
      // let the update unit finish its last pass
      repeat (PAD_COUNT + 4) @(negedge clk_i);
    end
  endtask

  task automatic write_enable(input logic value);
    begin
      cfg_enable_i = value;
      cfg_valid_i  = 1'b1;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      @(negedge clk_i);
      cfg_valid_i = 1'b0;
    end
  endtask

  // mostly short lives and short pulse patterns so pads cycle through
  // starting, rumbling and stopping within the run; now and then full-range values
  task automatic send_random_request();
    int          sel;
    int          on_sel;
    logic [1:0]  op;
    logic [15:0] dur;
    logic [16:0] on;
    logic [15:0] off;
    begin
      sel = $urandom_range(0, 99);
      if (sel < 50)      op = OP_TICK;
      else if (sel < 80) op = OP_START;
      else if (sel < 92) op = OP_STOP;
      else               op = OP_SPARE;
      dur = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
      on_sel = $urandom_range(0, 19);
      if (on_sel < 13)      on = 17'($urandom_range(0, 6));
      else if (on_sel < 16) on = ON_CONTINUOUS;
      else if (on_sel < 19) on = 17'($urandom);
      else                  on = 17'd65535;
      off = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
      send_request(op, 2'($urandom_range(0, 3)), dur, $signed(on), off);
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_enable_i     = 1'b0;
    in_valid_i       = 1'b0;
    op_i             = OP_TICK;
    pad_i            = '0;
    duration_ticks_i = '0;
    on_ticks_i       = '0;
    off_ticks_i      = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // service still off after reset: ticks report nothing, starts refused,
    // a stop still takes a pad out of its enabling mode
    send_request(OP_TICK, 2'd0, 16'd0, 17'sd0, 16'd0);
    send_request(OP_START, 2'd0, 16'd5, 17'sd1, 16'd1);
    send_request(OP_STOP, 2'd1, 16'd0, 17'sd0, 16'd0);
    send_request(OP_SPARE, 2'd3, 16'd0, 17'sd0, 16'd0);
    drain();
    write_enable(1'b1);

    // first enabled tick: enabling pads settle, the stopped one reports stop
    send_request(OP_TICK, 2'd0, 16'd0, 17'sd0, 16'd0);
    // continuous drive with zero life, full-range pattern, short pulses,
    // negative on-time other than continuous
    send_request(OP_START, 2'd0, 16'd0, ON_CONTINUOUS, 16'd0);
    send_request(OP_START, 2'd1, 16'hFFFF, 17'sd65535, 16'hFFFF);
    send_request(OP_START, 2'd2, 16'd3, 17'sd1, 16'd1);
    send_request(OP_START, 2'd3, 16'd5, -17'sd65536, 16'd3);
    // equal life is not shorter: refused
    send_request(OP_START, 2'd0, 16'd0, 17'sd2, 16'd2);
    repeat (6) send_request(OP_TICK, 2'd0, 16'd0, 17'sd0, 16'd0);
    send_request(OP_STOP, 2'd2, 16'd0, 17'sd0, 16'd0);
    // spare op with every payload bit set
    send_request(OP_SPARE, 2'd2, 16'hFFFF, -17'sd1, 16'hFFFF);
    send_request(OP_TICK, 2'd0, 16'd0, 17'sd0, 16'd0);
    // zero period: counter never returns to zero
    send_request(OP_START, 2'd3, 16'd10, 17'sd0, 16'd0);
    repeat (3) send_request(OP_TICK, 2'd0, 16'd0, 17'sd0, 16'd0);

    // random traffic, enabled; one full pause halfway through
    repeat (60) send_random_request();
    drain();
    repeat (60) send_random_request();

    // service off: ticks frozen, starts refused, stops still act
    drain();
    write_enable(1'b0);
    repeat (40) send_random_request();

    // back on; first stretch with no idling on either side
    drain();
    write_enable(1'b1);
    calm = 1'b1;
    repeat (40) send_random_request();
    calm = 1'b0;
    repeat (60) send_random_request();

    // brief switch off and on again
    drain();
    write_enable(1'b0);
    repeat (10) send_random_request();
    drain();
    write_enable(1'b1);
    repeat (30) send_random_request();

    drain();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/vmps_pkg.sv
rtl/vmps_ctrl.sv
rtl/vmps_dp.sv
rtl/vibration_motor_pulse_sequencer_unit.sv
verif/vibration_motor_pulse_sequencer_checker.sv
verif/vibration_motor_pulse_sequencer_unit_tb.sv
